// ===== sv/bb2d_pkg.sv =====
// Shared constants, types and helpers for the 2-D box blur core.
package bb2d_pkg;
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_RADIUS = 8;
   localparam int PIXEL_BITS = 16;
   localparam int ROW_SLOTS  = 2 * MAX_RADIUS + 2;
   localparam int MEM_DEPTH  = ROW_SLOTS * MAX_WIDTH;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);
   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int SLOT_W     = $clog2(ROW_SLOTS);
   localparam int RW         = $clog2(MAX_RADIUS + 1);
   localparam int AREA_MAX   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int DIV_W      = $clog2(AREA_MAX + 1);
   localparam int SUM_W      = $clog2(AREA_MAX * ((1 << PIXEL_BITS) - 1) + AREA_MAX + 1);
   localparam int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                      + MAX_RADIUS + 2);
   localparam int LANES      = 3;

   typedef struct packed {
      logic clear;
      logic acc;
      logic div_start;
   } lane_ctrl_type;

   function automatic logic [DIV_W-1:0] box_area(input logic [RW-1:0] r);
      logic [DIV_W-1:0] side;
      side = DIV_W'(2 * r + 1);
      return DIV_W'(side * side);
   endfunction
endpackage

// ===== sv/box_blur_2d_clamp_edge_core.sv =====
// Top level: streaming 2-D box blur with clamp-to-edge borders, RGB lanes.
// Usage:
//  req_* carries one pixel per request in raster order; tuser = drain.
//  After the frame's last pixel send r*width+r drain requests to flush.
//  rsp_* carries blurred pixels; tlast marks the frame's final pixel.
//  csr_* writes frame_width (0), frame_height (1), blur_radius (2)
//  while the core is idle.
// Timing:
//  A request that yields no result leaves the core idle and ready. A request that
//  yields a result holds req_tready low until it is done: the row store has one
//  read port, so the window is summed one pixel per cycle across three color lanes,
//  then each lane runs a 25-step serial divider.
// Reset: counters clear, registers return to 256x256, radius 1. The row
//  store needs no clearing; every window read hits pixels of this frame.
// Stall: a finished result waits in the output register; the core keeps taking
//  requests until a second result is ready, which waits until the first leaves.
module box_blur_2d_clamp_edge_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // red_in[15:0], green_in[31:16], blue_in[47:32]
   input  logic        req_tuser,   // drain
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // red_out[15:0], green_out[31:16], blue_out[47:32]
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);
   import bb2d_pkg::*;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_RADIUS = 2'd2;

   typedef enum logic [2:0] {S_IDLE, S_RUN, S_FLUSH, S_DIVS, S_DIV, S_DONE} state_type;

   state_type state_ff;
   logic [8:0] width_ff, height_ff;
   logic [3:0] radius_ff;

   logic [8:0]      w, h;
   logic [RW-1:0]   r;
   logic [RW:0]     r2;
   logic [12:0]     lag;
   logic [DIV_W-1:0] area;

   always_comb begin
      w = (width_ff == '0) ? 9'd1 : ((width_ff > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_ff);
      h = (height_ff == '0) ? 9'd1
          : ((height_ff > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_ff);
      r = (radius_ff > 4'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_ff);
      r2 = {r, 1'b0};
      lag = 13'(13'(r) * 13'(w) + 13'(r));
      area = box_area(r);
   end

   logic [CNT_W-1:0]  in_cnt_ff;
   logic [XW-1:0]     ipx_ff;
   logic [8:0]        ipy_ff;
   logic [SLOT_W-1:0] islot_ff;
   logic [XW-1:0]     ox_ff;
   logic [YW-1:0]     oy_ff;
   logic [SLOT_W-1:0] oslot_ff;

   logic signed [9:0] rx_ff, rx0_ff, ry_ff;
   logic [XW-1:0]     xx_ff, xx0_ff;
   logic [SLOT_W-1:0] ys_ff;
   logic [RW:0]       ci_ff, ri_ff;

   logic [47:0] mem [MEM_DEPTH];
   logic [47:0] rd_data_ff;
   logic        rd_vld_ff;
   logic        rd_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;

   logic        out_vld_ff, out_last_ff;
   logic [47:0] out_data_ff;

   logic req_acc, in_done, wr_en, due, last, load_out;
   logic [CNT_W-1:0] cnt_n;
   logic [RW-1:0]    m;
   logic [SLOT_W:0]  t;
   logic signed [9:0] nx, ny;

   lane_ctrl_type ctrl;
   logic [PIXEL_BITS-1:0] mean [LANES];
   logic [LANES-1:0] busy;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign in_done    = (ipy_ff >= h);
   assign wr_en      = req_acc && !in_done;
   assign cnt_n      = in_cnt_ff + 1'b1;
   assign due        = (cnt_n > CNT_W'(lag));
   assign last       = (9'(ox_ff) == w - 9'd1) && (9'(oy_ff) == h - 9'd1);
   assign load_out   = (state_ff == S_DONE) && (!out_vld_ff || rsp_tready);
   assign rd_en      = (state_ff == S_RUN);
   assign wr_addr    = ADDR_W'(ADDR_W'(islot_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ipx_ff));
   assign rd_addr    = ADDR_W'(ADDR_W'(ys_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xx_ff));
   assign m          = (oy_ff >= YW'(r)) ? r : RW'(oy_ff);
   assign t          = {1'b0, oslot_ff} - (SLOT_W + 1)'(m);
   assign nx         = rx_ff + 10'sd1;
   assign ny         = ry_ff + 10'sd1;

   assign ctrl.clear     = req_acc && due;
   assign ctrl.acc       = rd_vld_ff;
   assign ctrl.div_start = (state_ff == S_DIVS);

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      bb2d_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .sample  (rd_data_ff[i*PIXEL_BITS +: PIXEL_BITS]),
         .divisor (area),
         .mean    (mean[i]),
         .busy    (busy[i])
      );
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_tuser ? 48'd0 : req_tdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= {mean[2], mean[1], mean[0]};
         out_last_ff <= last;
      end
      if (reset) begin
         state_ff   <= S_IDLE;
         width_ff   <= 9'd256;
         height_ff  <= 9'd256;
         radius_ff  <= 4'd1;
         in_cnt_ff  <= '0;
         ipx_ff     <= '0;
         ipy_ff     <= '0;
         islot_ff   <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
         oslot_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         if (csr_we) begin
            case (csr_index)
               REG_WIDTH:  width_ff  <= csr_wdata;
               REG_HEIGHT: height_ff <= csr_wdata;
               REG_RADIUS: radius_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
         if (load_out) begin
            out_vld_ff <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  in_cnt_ff <= cnt_n;
                  if (wr_en) begin
                     if (9'(ipx_ff) == w - 9'd1) begin
                        ipx_ff   <= '0;
                        ipy_ff   <= ipy_ff + 1'b1;
                        islot_ff <= (islot_ff == SLOT_W'(ROW_SLOTS - 1)) ? '0
                                    : islot_ff + 1'b1;
                     end else begin
                        ipx_ff <= ipx_ff + 1'b1;
                     end
                  end
                  if (due) begin
                     state_ff <= S_RUN;
                     rx_ff    <= $signed({2'b00, ox_ff}) - $signed(10'(r));
                     rx0_ff   <= $signed({2'b00, ox_ff}) - $signed(10'(r));
                     ry_ff    <= $signed({2'b00, oy_ff}) - $signed(10'(r));
                     xx_ff    <= (ox_ff >= XW'(r)) ? ox_ff - XW'(r) : '0;
                     xx0_ff   <= (ox_ff >= XW'(r)) ? ox_ff - XW'(r) : '0;
                     ys_ff    <= t[SLOT_W] ? SLOT_W'(t + (SLOT_W + 1)'(ROW_SLOTS))
                                 : SLOT_W'(t);
                     ci_ff    <= '0;
                     ri_ff    <= '0;
                  end
               end
            end
            S_RUN: begin
               if (ci_ff == r2) begin
                  ci_ff <= '0;
                  rx_ff <= rx0_ff;
                  xx_ff <= xx0_ff;
                  if (ri_ff == r2) begin
                     state_ff <= S_FLUSH;
                  end else begin
                     ri_ff <= ri_ff + 1'b1;
                     ry_ff <= ny;
                     if (ny > 10'sd0 && ny <= $signed({1'b0, h - 9'd1})) begin
                        ys_ff <= (ys_ff == SLOT_W'(ROW_SLOTS - 1)) ? '0 : ys_ff + 1'b1;
                     end
                  end
               end else begin
                  ci_ff <= ci_ff + 1'b1;
                  rx_ff <= nx;
                  if (nx > 10'sd0 && nx <= $signed({1'b0, w - 9'd1})) begin
                     xx_ff <= xx_ff + 1'b1;
                  end
               end
            end
            S_FLUSH: state_ff <= S_DIVS;
            S_DIVS:  state_ff <= S_DIV;
            S_DIV: begin
               if (busy == '0) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (load_out) begin
                  state_ff <= S_IDLE;
                  if (last) begin
                     in_cnt_ff <= '0;
                     ipx_ff    <= '0;
                     ipy_ff    <= '0;
                     islot_ff  <= '0;
                     ox_ff     <= '0;
                     oy_ff     <= '0;
                     oslot_ff  <= '0;
                  end else if (9'(ox_ff) == w - 9'd1) begin
                     ox_ff    <= '0;
                     oy_ff    <= oy_ff + 1'b1;
                     oslot_ff <= (oslot_ff == SLOT_W'(ROW_SLOTS - 1)) ? '0
                                 : oslot_ff + 1'b1;
                  end else begin
                     ox_ff <= ox_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
endmodule

// ===== sv/bb2d_lane.sv =====
// One color lane: window accumulator and serial rounding divider.
module bb2d_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  bb2d_pkg::lane_ctrl_type        ctrl,
   input  logic [bb2d_pkg::PIXEL_BITS-1:0] sample,
   input  logic [bb2d_pkg::DIV_W-1:0]     divisor,
   output logic [bb2d_pkg::PIXEL_BITS-1:0] mean,
   output logic                           busy
);
   import bb2d_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W:0]    rem_sh;

   always_comb begin
      sum_in  = sum_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.acc) begin
         sum_in = sum_ff + SUM_W'(sample);
      end
      if (ctrl.div_start) begin
         quo_in  = sum_ff + SUM_W'(divisor >> 1);
         rem_in  = '0;
         step_in = STEP_W'(SUM_W);
      end else if (step_ff != '0) begin
         step_in = step_ff - 1'b1;
         if (rem_sh >= {1'b0, divisor}) begin
            rem_in = DIV_W'(rem_sh - {1'b0, divisor});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = DIV_W'(rem_sh);
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   assign mean = quo_ff[PIXEL_BITS-1:0];
   assign busy = (step_ff != '0);
endmodule

// ===== tb/tb_checker.sv =====
// Checker: predicts blurred pixels from observed requests and compares responses.
`timescale 1ns / 100ps
module tb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata,
   output int          fail_count,
   output int          pending
);
   import bb2d_pkg::*;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_RADIUS = 2'd2;

   typedef struct packed {
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
   } rgb_type;

   typedef struct {
      rgb_type pix;
      logic    last;
   } blur_pixel_type;

   rgb_type        row_store [ROW_SLOTS][MAX_WIDTH];
   blur_pixel_type blur_queue [$];
   logic [8:0]     width_reg, height_reg;
   logic [3:0]     radius_reg;
   int             in_pos;

   assign pending = blur_queue.size();

   function automatic int clamp_to(input int v, input int lim);
      if (v < 0) return 0;
      if (v >= lim) return lim - 1;
      return v;
   endfunction

   task automatic predict_blur(input logic [47:0] d, input logic drn);
      int w, h, r, total, lag, q, x, y, yy, xx, area;
      longint unsigned s_r, s_g, s_b;
      blur_pixel_type e;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
      r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
      total = w * h;
      lag = r * w + r;
      if (in_pos < total)
         row_store[(in_pos / w) % ROW_SLOTS][in_pos % w] = drn ? '0 : rgb_type'(d);
      in_pos++;
      if (in_pos <= lag) return;
      q = in_pos - 1 - lag;
      if (q > total - 1) q = total - 1;
      e.last = (q == total - 1);
      x = q % w;
      y = q / w;
      s_r = 0; s_g = 0; s_b = 0;
      for (int dy = -r; dy <= r; dy++) begin
         yy = clamp_to(y + dy, h) % ROW_SLOTS;
         for (int dx = -r; dx <= r; dx++) begin
            xx = clamp_to(x + dx, w);
            s_r += row_store[yy][xx].red;
            s_g += row_store[yy][xx].green;
            s_b += row_store[yy][xx].blue;
         end
      end
      area = (2 * r + 1) * (2 * r + 1);
      e.pix.red   = 16'((s_r + area / 2) / area);
      e.pix.green = 16'((s_g + area / 2) / area);
      e.pix.blue  = 16'((s_b + area / 2) / area);
      if (e.last) in_pos = 0;
      blur_queue = {blur_queue, e};
   endtask

   task automatic check_blur(input rgb_type got, input logic got_last);
      blur_pixel_type e;
      if (blur_queue.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected response: %h last=%0b", got, got_last);
         return;
      end
      e = blur_queue.pop_front();
      if (got !== e.pix || got_last !== e.last) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch: expected rgb=%h last=%0b, got rgb=%h last=%0b",
                     e.pix, e.last, got, got_last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg  <= 9'd256;
         height_reg <= 9'd256;
         radius_reg <= 4'd1;
         in_pos     = 0;
         fail_count = 0;
         blur_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_WIDTH:  width_reg  <= csr_wdata;
               REG_HEIGHT: height_reg <= csr_wdata;
               REG_RADIUS: radius_reg <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_blur(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) check_blur(rgb_type'(rsp_tdata), rsp_tlast);
      end
   end
endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives frames through the box blur core and reports the verdict.
`timescale 1ns / 100ps
module tb_top;
   import bb2d_pkg::*;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_RADIUS = 2'd2;
   localparam int SETTLE_CYCLES = AREA_MAX + 100;
   localparam longint CYCLE_LIMIT = 20_000_000;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tuser;
   logic [47:0] req_tdata;
   logic        rsp_tvalid, rsp_tlast;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [8:0]  csr_wdata;
   int          fail_count, pending;
   int          items_sent;
   logic        no_gaps;
   longint      cycles = 0;

   box_blur_2d_clamp_edge_core DUT (.*);

   tb_checker u_checker (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response back-pressure
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic int pick_gap();
      int p;
      if (no_gaps) return 0;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_req(input logic [47:0] d, input logic drn);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= d;
      req_tuser  <= drn;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_out();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_regs(input logic [8:0] w, input logic [8:0] h, input logic [3:0] r);
      csr_we <= 1'b1; csr_index <= REG_WIDTH;  csr_wdata <= w; @(posedge clock);
      csr_index <= REG_HEIGHT; csr_wdata <= h; @(posedge clock);
      csr_index <= REG_RADIUS; csr_wdata <= {5'd0, r}; @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [47:0] rand_pixel();
      return {rand_sample(), rand_sample(), rand_sample()};
   endfunction

   task automatic run_frame(input logic [8:0] w_raw, input logic [8:0] h_raw,
                            input logic [3:0] r_raw, input bit hold);
      int w, h, r, total, lag, hold_at;
      w = (w_raw == 0) ? 1 : (w_raw > MAX_WIDTH ? MAX_WIDTH : w_raw);
      h = (h_raw == 0) ? 1 : (h_raw > MAX_HEIGHT ? MAX_HEIGHT : h_raw);
      r = (r_raw > MAX_RADIUS) ? MAX_RADIUS : r_raw;
      total = w * h;
      lag = r * w + r;
      hold_at = hold ? $urandom_range(0, total - 1) : -1;
      no_gaps = ($urandom_range(0, 4) == 0);
      write_regs(w_raw, h_raw, r_raw);
      for (int i = 0; i < total; i++) begin
         if (i == hold_at) drain_out();
         send_req(rand_pixel(), $urandom_range(0, 15) == 0);
      end
      // flush; a pixel past the frame end is ignored
      for (int i = 0; i < lag; i++)
         send_req(rand_pixel(), $urandom_range(0, 3) != 0);
      drain_out();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [47:0] dir_pix [12];
      clock = 0; reset = 1; items_sent = 0; no_gaps = 0;
      req_tvalid = 0; req_tdata = '0; req_tuser = 0;
      csr_we = 0; csr_index = '0; csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 4x3 frame, extreme samples, a drain in-frame, a pixel during flush
      dir_pix = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555,
                  48'hFFFF_0000_FFFF, 48'h0, 48'h0000_FFFF_0000, 48'h0123_4567_89AB,
                  48'hFFFF_FFFF_FFFF, 48'h8000_0001_8000, 48'h0, 48'hFEDC_BA98_7654};
      write_regs(9'd4, 9'd3, 4'd1);
      for (int i = 0; i < 12; i++) send_req(dir_pix[i], i == 5);
      for (int i = 0; i < 5; i++) send_req(48'hFFFF_FFFF_FFFF, i != 2);
      drain_out();
      repeat (SETTLE_CYCLES) @(posedge clock);

      run_frame(9'd1, 9'd1, 4'd0, 1'b1);
      run_frame(9'd0, 9'd0, 4'd15, 1'b0);
      run_frame(9'd256, 9'd1, 4'd1, 1'b0);
      run_frame(9'd1, 9'd300, 4'd9, 1'b1);
      run_frame(9'd511, 9'd1, 4'd0, 1'b0);

      while (items_sent < 1300)
         run_frame(9'($urandom_range(1, 24)), 9'($urandom_range(1, 10)),
                   4'($urandom_range(0, 15)), $urandom_range(0, 3) == 0);

      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
